>>> rtl/core/swalk_pkg.sv
// ----------------------------------------------------------------------------
// swalk_pkg
// Shared types and constants of the structure table walker.
// ----------------------------------------------------------------------------
package swalk_pkg;

  localparam int OFF_W   = 16;
  localparam int CMP_W   = (OFF_W > 16) ? OFF_W : 16;
  localparam int PADDR_W = 4;

  localparam logic [7:0] END_TYPE = 8'd127;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WANTED_TYPE   = 2'd0;
  localparam logic [1:0] REG_WANTED_STRING = 2'd1;
  localparam logic [1:0] REG_TABLE_LENGTH  = 2'd2;

  localparam logic KIND_STRUCT = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_MATCH     = 2'd1;
  localparam logic [1:0] ST_END_MARK  = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  struct_type;
    logic [15:0] start_offset;
    logic [7:0]  formatted_length;
    logic [7:0]  string_count;
    logic        is_first_match;
    logic [15:0] string_offset;
    logic        string_found;
    logic [1:0]  end_status;
    logic        last;
  } rec_t;

endpackage

>>> rtl/core/swalk_byte_if.sv
// ----------------------------------------------------------------------------
// swalk_byte_if
// Table byte channel: valid/ready handshake carrying one table byte per beat.
// ----------------------------------------------------------------------------
interface swalk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;

  modport source (output valid, output table_byte, input ready);
  modport sink   (input valid, input table_byte, output ready);
endinterface

>>> rtl/core/swalk_rec_if.sv
// ----------------------------------------------------------------------------
// swalk_rec_if
// Result channel: valid/ready handshake carrying one walker record per beat.
// ----------------------------------------------------------------------------
interface swalk_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [7:0]  struct_type;
  logic [15:0] start_offset;
  logic [7:0]  formatted_length;
  logic [7:0]  string_count;
  logic        is_first_match;
  logic [15:0] string_offset;
  logic        string_found;
  logic [1:0]  end_status;
  logic        last;

  modport source (output valid, output record_kind, output struct_type, output start_offset,
                  output formatted_length, output string_count, output is_first_match,
                  output string_offset, output string_found, output end_status,
                  output last, input ready);
  modport sink   (input valid, input record_kind, input struct_type, input start_offset,
                  input formatted_length, input string_count, input is_first_match,
                  input string_offset, input string_found, input end_status,
                  input last, output ready);
endinterface

>>> rtl/core/smbios_structure_table_walker_top.sv
// ----------------------------------------------------------------------------
// smbios_structure_table_walker_top
// Walks an SMBIOS structure table one byte per beat and reports structures.
// ----------------------------------------------------------------------------
// The walker takes one table byte per cycle unless stalled and updates its parse
// state in the same cycle; each finished structure (at its double NUL) gives one
// record, and the walk ends with one table end record on type 127 or when
// table_length runs out, after which bytes are taken and dropped until reset.
// Records enter a three-deep output queue the cycle after their byte, so a
// record that finds the queue empty is visible at the result port then. A byte
// is taken every cycle as long as at most one record waits in the queue (two
// while the result side is draining); otherwise input is held off. The user must
// write registers over the APB port while the walker is idle (not enforced).

module smbios_structure_table_walker_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swalk_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  swalk_byte_if.sink                     tbl,
  swalk_rec_if.source                    rec
);

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LENGTH,
    PH_FORMAT,
    PH_STRINGS
  } phase_t;

  localparam logic [swalk_pkg::OFF_W-1:0] OFF_MAX = {swalk_pkg::OFF_W{1'b1}};

  // configuration
  logic [6:0]  wanted_type;
  logic [7:0]  wanted_string;
  logic [15:0] table_length;

  // walk state
  phase_t                        phase, phase_next;
  logic [swalk_pkg::OFF_W-1:0]   byte_offset, byte_offset_next;
  logic [swalk_pkg::OFF_W-1:0]   struct_start, struct_start_next;
  logic [7:0]                    cur_type, cur_type_next;
  logic [7:0]                    cur_length, cur_length_next;
  logic [7:0]                    pos_in_struct, pos_in_struct_next;
  logic                          prev_was_zero, prev_was_zero_next;
  logic [7:0]                    strings_seen, strings_seen_next;
  logic [swalk_pkg::OFF_W-1:0]   hit_offset, hit_offset_next;
  logic                          hit_flag, hit_flag_next;
  logic                          match_seen, match_seen_next;
  logic                          finished, finished_next;

  // results of the current byte
  swalk_pkg::rec_t r0, r1;
  logic [1:0]      n_res;

  // output queue
  swalk_pkg::rec_t q [3];
  swalk_pkg::rec_t q_next [3];
  logic [1:0]      count, count_next;

  logic acc, pop, cfg_wr;

  assign pop    = rec.valid && rec.ready;
  assign acc    = tbl.valid && tbl.ready;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  // room for two more records once the head leaves
  assign tbl.ready = (count <= 2'd1) || (count == 2'd2 && rec.ready);

  always_comb begin
    case (paddr[3:2])
      swalk_pkg::REG_WANTED_TYPE:   prdata = {25'b0, wanted_type};
      swalk_pkg::REG_WANTED_STRING: prdata = {24'b0, wanted_string};
      swalk_pkg::REG_TABLE_LENGTH:  prdata = {16'b0, table_length};
      default:                      prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_type   <= '0;
      wanted_string <= '0;
      table_length  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        swalk_pkg::REG_WANTED_TYPE:   wanted_type   <= pwdata[6:0];
        swalk_pkg::REG_WANTED_STRING: wanted_string <= pwdata[7:0];
        swalk_pkg::REG_TABLE_LENGTH:  table_length  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // per-byte parse step
  always_comb begin
    logic [swalk_pkg::OFF_W-1:0] off_inc;
    logic                        exh_now, exh_inc;
    logic [7:0]                  b, eff, pos_inc;
    logic [7:0]                  ss_b, ss_c;
    logic                        hf_b, hf_c;
    logic [swalk_pkg::OFF_W-1:0] ho_b, ho_c;
    logic                        first;

    b       = tbl.table_byte;
    off_inc = (byte_offset == OFF_MAX) ? byte_offset : byte_offset + 1'b1;
    exh_now = (swalk_pkg::CMP_W'(byte_offset) >= swalk_pkg::CMP_W'(table_length))
              || (byte_offset == OFF_MAX);
    exh_inc = (swalk_pkg::CMP_W'(off_inc) >= swalk_pkg::CMP_W'(table_length))
              || (off_inc == OFF_MAX);
    eff     = (cur_length < 8'd2) ? 8'd2 : cur_length;
    pos_inc = pos_in_struct + 8'd1;
    first   = (cur_type == {1'b0, wanted_type}) && !match_seen;

    // up to two new strings per byte: a leading empty string and this one
    ss_b = strings_seen;
    hf_b = hit_flag;
    ho_b = hit_offset;
    if (strings_seen == 8'd0 && prev_was_zero) begin
      ss_b = 8'd1;
      if (wanted_string == 8'd1 && !hit_flag) begin
        hf_b = 1'b1;
        ho_b = byte_offset - 1'b1;
      end
    end
    ss_c = ss_b;
    hf_c = hf_b;
    ho_c = ho_b;
    if ((strings_seen == 8'd0 || prev_was_zero) && ss_b != 8'hFF) begin
      ss_c = ss_b + 8'd1;
      if (wanted_string != 8'd0 && ss_c == wanted_string && !hf_b) begin
        hf_c = 1'b1;
        ho_c = byte_offset;
      end
    end

    phase_next         = phase;
    byte_offset_next   = byte_offset;
    struct_start_next  = struct_start;
    cur_type_next      = cur_type;
    cur_length_next    = cur_length;
    pos_in_struct_next = pos_in_struct;
    prev_was_zero_next = prev_was_zero;
    strings_seen_next  = strings_seen;
    hit_offset_next    = hit_offset;
    hit_flag_next      = hit_flag;
    match_seen_next    = match_seen;
    finished_next      = finished;
    n_res              = 2'd0;

    r0                  = '0;
    r0.record_kind      = swalk_pkg::KIND_STRUCT;
    r0.struct_type      = cur_type;
    r0.start_offset     = 16'(struct_start);
    r0.formatted_length = cur_length;
    r0.string_count     = strings_seen;
    r0.is_first_match   = first;
    r0.string_offset    = hit_flag ? 16'(hit_offset) : 16'd0;
    r0.string_found     = hit_flag;
    r0.end_status       = swalk_pkg::ST_NONE;
    r0.last             = 1'b1;

    r1              = '0;
    r1.record_kind  = swalk_pkg::KIND_END;
    r1.start_offset = 16'(off_inc);
    r1.end_status   = (match_seen || first) ? swalk_pkg::ST_MATCH : swalk_pkg::ST_EXHAUSTED;
    r1.last         = 1'b1;

    if (acc && !finished) begin
      case (phase)
        PH_TYPE: begin
          if (exh_now || b == swalk_pkg::END_TYPE) begin
            // end record goes out alone, from slot r0
            r0              = '0;
            r0.record_kind  = swalk_pkg::KIND_END;
            r0.start_offset = 16'(byte_offset);
            r0.end_status   = match_seen ? swalk_pkg::ST_MATCH :
                              (exh_now ? swalk_pkg::ST_EXHAUSTED : swalk_pkg::ST_END_MARK);
            r0.last         = 1'b1;
            n_res           = 2'd1;
            finished_next   = 1'b1;
          end else begin
            cur_type_next      = b;
            struct_start_next  = byte_offset;
            strings_seen_next  = 8'd0;
            prev_was_zero_next = 1'b0;
            hit_flag_next      = 1'b0;
            hit_offset_next    = '0;
            phase_next         = PH_LENGTH;
            byte_offset_next   = off_inc;
          end
        end
        PH_LENGTH: begin
          cur_length_next    = b;
          pos_in_struct_next = 8'd2;
          phase_next         = (b <= 8'd2) ? PH_STRINGS : PH_FORMAT;
          byte_offset_next   = off_inc;
        end
        PH_FORMAT: begin
          pos_in_struct_next = pos_inc;
          if (pos_inc >= eff) phase_next = PH_STRINGS;
          byte_offset_next = off_inc;
        end
        PH_STRINGS: begin
          byte_offset_next = off_inc;
          if (b == 8'd0) begin
            if (prev_was_zero) begin
              // double NUL closes the structure
              if (first) match_seen_next = 1'b1;
              phase_next         = PH_TYPE;
              prev_was_zero_next = 1'b0;
              if (exh_inc) begin
                r0.last       = 1'b0;
                n_res         = 2'd2;
                finished_next = 1'b1;
              end else begin
                n_res = 2'd1;
              end
            end else begin
              prev_was_zero_next = 1'b1;
            end
          end else begin
            strings_seen_next  = ss_c;
            hit_flag_next      = hf_c;
            hit_offset_next    = ho_c;
            prev_was_zero_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output queue: shift out the head, then append this byte's records
  always_comb begin
    logic [1:0] base;
    base = count - {1'b0, pop};
    for (int i = 0; i < 3; i++) begin
      if (pop && i < 2) q_next[i] = q[i+1];
      else              q_next[i] = q[i];
      if (n_res != 2'd0 && 2'(i) == base)                  q_next[i] = r0;
      if (n_res == 2'd2 && 2'(i) == base + 2'd1)           q_next[i] = r1;
    end
    count_next = base + n_res;
  end

  assign rec.valid            = (count != 2'd0);
  assign rec.record_kind      = q[0].record_kind;
  assign rec.struct_type      = q[0].struct_type;
  assign rec.start_offset     = q[0].start_offset;
  assign rec.formatted_length = q[0].formatted_length;
  assign rec.string_count     = q[0].string_count;
  assign rec.is_first_match   = q[0].is_first_match;
  assign rec.string_offset    = q[0].string_offset;
  assign rec.string_found     = q[0].string_found;
  assign rec.end_status       = q[0].end_status;
  assign rec.last             = q[0].last;

  always_ff @(posedge clk) begin
    q <= q_next;
    if (rst) begin
      count         <= '0;
      phase         <= PH_TYPE;
      byte_offset   <= '0;
      struct_start  <= '0;
      cur_type      <= '0;
      cur_length    <= '0;
      pos_in_struct <= '0;
      prev_was_zero <= 1'b0;
      strings_seen  <= '0;
      hit_offset    <= '0;
      hit_flag      <= 1'b0;
      match_seen    <= 1'b0;
      finished      <= 1'b0;
    end else begin
      count         <= count_next;
      phase         <= phase_next;
      byte_offset   <= byte_offset_next;
      struct_start  <= struct_start_next;
      cur_type      <= cur_type_next;
      cur_length    <= cur_length_next;
      pos_in_struct <= pos_in_struct_next;
      prev_was_zero <= prev_was_zero_next;
      strings_seen  <= strings_seen_next;
      hit_offset    <= hit_offset_next;
      hit_flag      <= hit_flag_next;
      match_seen    <= match_seen_next;
      finished      <= finished_next;
    end
  end

endmodule
